// ----- hdl/kps_pkg.sv -----
// ============================================================================
// kps_pkg
// Shared types and constants for the kinetic propagator stencil.
// ============================================================================
`default_nettype none

package kps_pkg;

    localparam int INT_BITS  = 4;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIAG_HALF_RE = 3'd0,
        CFG_DIAG_HALF_IM = 3'd1,
        CFG_DIAG_FULL_RE = 3'd2,
        CFG_DIAG_FULL_IM = 3'd3,
        CFG_OFF_HALF_RE  = 3'd4,
        CFG_OFF_HALF_IM  = 3'd5,
        CFG_OFF_FULL_RE  = 3'd6,
        CFG_OFF_FULL_IM  = 3'd7
    } t_cfg_idx;

endpackage : kps_pkg

`default_nettype wire

// ----- hdl/kps_cmul.sv -----
// ============================================================================
// kps_cmul
// Product stage: eight signed coefficient-by-sample products, registered.
// ============================================================================
`default_nettype none

module kps_cmul
    import kps_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [DATA_WIDTH-1:0]      i_dr,
    input  wire logic signed [DATA_WIDTH-1:0]      i_di,
    input  wire logic signed [DATA_WIDTH-1:0]      i_or,
    input  wire logic signed [DATA_WIDTH-1:0]      i_oi,
    input  wire logic signed [DATA_WIDTH-1:0]      i_cr,
    input  wire logic signed [DATA_WIDTH-1:0]      i_ci,
    input  wire logic signed [DATA_WIDTH-1:0]      i_nr,
    input  wire logic signed [DATA_WIDTH-1:0]      i_ni,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [2*DATA_WIDTH-1:0]         o_re_prod [4],
    output logic signed [2*DATA_WIDTH-1:0]         o_im_prod [4]
);

    localparam int PW = 2 * DATA_WIDTH;

    logic                 r_valid;
    logic signed [PW-1:0] r_re_prod [4];
    logic signed [PW-1:0] r_im_prod [4];
    logic signed [PW-1:0] n_re_prod [4];
    logic signed [PW-1:0] n_im_prod [4];
    logic                 w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_re_prod[0] = PW'(i_dr) * PW'(i_cr);
        n_re_prod[1] = PW'(i_di) * PW'(i_ci);
        n_re_prod[2] = PW'(i_or) * PW'(i_nr);
        n_re_prod[3] = PW'(i_oi) * PW'(i_ni);
        n_im_prod[0] = PW'(i_dr) * PW'(i_ci);
        n_im_prod[1] = PW'(i_di) * PW'(i_cr);
        n_im_prod[2] = PW'(i_or) * PW'(i_ni);
        n_im_prod[3] = PW'(i_oi) * PW'(i_nr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_re_prod <= n_re_prod;
            r_im_prod <= n_im_prod;
        end
    end

    assign o_valid   = r_valid;
    assign o_re_prod = r_re_prod;
    assign o_im_prod = r_im_prod;

endmodule : kps_cmul

`default_nettype wire

// ----- hdl/kps_pair.sv -----
// ============================================================================
// kps_pair
// Pair-sum stage: fold the eight products into two partial sums per part.
// ============================================================================
`default_nettype none

module kps_pair
    import kps_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [2*DATA_WIDTH-1:0]    i_re_prod [4],
    input  wire logic signed [2*DATA_WIDTH-1:0]    i_im_prod [4],
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [2*DATA_WIDTH:0]           o_re_a,
    output logic signed [2*DATA_WIDTH:0]           o_re_b,
    output logic signed [2*DATA_WIDTH:0]           o_im_a,
    output logic signed [2*DATA_WIDTH:0]           o_im_b
);

    localparam int SW = 2 * DATA_WIDTH + 1;

    logic                 r_valid;
    logic signed [SW-1:0] r_re_a;
    logic signed [SW-1:0] r_re_b;
    logic signed [SW-1:0] r_im_a;
    logic signed [SW-1:0] r_im_b;
    logic                 w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_re_a <= SW'(i_re_prod[0]) - SW'(i_re_prod[1]);
            r_re_b <= SW'(i_re_prod[2]) - SW'(i_re_prod[3]);
            r_im_a <= SW'(i_im_prod[0]) + SW'(i_im_prod[1]);
            r_im_b <= SW'(i_im_prod[2]) + SW'(i_im_prod[3]);
        end
    end

    assign o_valid = r_valid;
    assign o_re_a  = r_re_a;
    assign o_re_b  = r_re_b;
    assign o_im_a  = r_im_a;
    assign o_im_b  = r_im_b;

endmodule : kps_pair

`default_nettype wire

// ----- hdl/kps_round.sv -----
// ============================================================================
// kps_round
// Result stage: final sum, round to nearest, rescale and saturate.
// ============================================================================
`default_nettype none

module kps_round
    import kps_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [2*DATA_WIDTH:0]      i_re_a,
    input  wire logic signed [2*DATA_WIDTH:0]      i_re_b,
    input  wire logic signed [2*DATA_WIDTH:0]      i_im_a,
    input  wire logic signed [2*DATA_WIDTH:0]      i_im_b,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [DATA_WIDTH-1:0]           o_new_re,
    output logic signed [DATA_WIDTH-1:0]           o_new_im,
    output logic                                   o_sat
);

    localparam int FRAC = DATA_WIDTH - INT_BITS;
    localparam int AW   = 2 * DATA_WIDTH + 2;
    localparam int HW   = AW - FRAC - DATA_WIDTH + 1;
    localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC - 1);
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_new_re;
    logic signed [DATA_WIDTH-1:0] r_new_im;
    logic                         r_sat;
    logic signed [AW-1:0]         w_re_acc;
    logic signed [AW-1:0]         w_im_acc;
    logic [HW-1:0]                w_re_hi;
    logic [HW-1:0]                w_im_hi;
    logic                         w_re_fit;
    logic                         w_im_fit;
    logic signed [DATA_WIDTH-1:0] n_new_re;
    logic signed [DATA_WIDTH-1:0] n_new_im;
    logic                         w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        w_re_acc = AW'(i_re_a) + AW'(i_re_b) + RND;
        w_im_acc = AW'(i_im_a) + AW'(i_im_b) + RND;
        w_re_hi  = w_re_acc[AW-1:FRAC+DATA_WIDTH-1];
        w_im_hi  = w_im_acc[AW-1:FRAC+DATA_WIDTH-1];
        w_re_fit = (&w_re_hi) || !(|w_re_hi);
        w_im_fit = (&w_im_hi) || !(|w_im_hi);
        if (w_re_fit) begin
            n_new_re = w_re_acc[FRAC+DATA_WIDTH-1:FRAC];
        end else begin
            n_new_re = w_re_acc[AW-1] ? MIN_VAL : MAX_VAL;
        end
        if (w_im_fit) begin
            n_new_im = w_im_acc[FRAC+DATA_WIDTH-1:FRAC];
        end else begin
            n_new_im = w_im_acc[AW-1] ? MIN_VAL : MAX_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_new_re <= n_new_re;
            r_new_im <= n_new_im;
            r_sat    <= !(w_re_fit && w_im_fit);
        end
    end

    assign o_valid  = r_valid;
    assign o_new_re = r_new_re;
    assign o_new_im = r_new_im;
    assign o_sat    = r_sat;

endmodule : kps_round

`default_nettype wire

// ----- hdl/kinetic_propagator_stencil.sv -----
// ============================================================================
// kinetic_propagator_stencil
// One mesh point of the split-operator kinetic step: complex
// diag*centre + off*neighbor in signed Q4.28, rounded and saturated.
//
//   channel   dir  handshake                   payload
//   s_axis    in   i_s_axis_tvalid/o_..tready  tdata: 6 samples, tuser: kind
//   m_axis    out  o_m_axis_tvalid/i_..tready  tdata: new sample, tuser: sat
//   cfg       in   i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while m_axis is ready; a beat passes the input
// register, product register, pair-sum register and result register in turn.
// Each stage holds its beat while the next one is full, so the input side
// keeps taking beats until all four registers are occupied.
// Reset is synchronous; it empties the pipe and loads the coefficient
// registers with diag = 1.0 and off = 0.
// ============================================================================
`default_nettype none

module kinetic_propagator_stencil
    import kps_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_cfg_wr_en,
    input  wire t_cfg_idx                                   i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]                      i_cfg_data,
    input  wire logic                                       i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    // left_re, left_im, centre_re, centre_im, right_re, right_im
    input  wire logic [((6*DATA_WIDTH+7)/8)*8-1:0]          i_s_axis_tdata,
    // func, point_odd
    input  wire logic [1:0]                                 i_s_axis_tuser,
    output logic                                            o_m_axis_tvalid,
    input  wire logic                                       i_m_axis_tready,
    // new_re, new_im
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]               o_m_axis_tdata,
    // saturated
    output logic [0:0]                                      o_m_axis_tuser
);

    localparam int DW      = DATA_WIDTH;
    localparam int OUT_W   = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam logic [DW-1:0] ONE = DW'(1) << (DW - INT_BITS);

    logic [DW-1:0]        r_cfg [8];
    logic                 r_in_valid;
    logic                 r_func;
    logic signed [DW-1:0] r_cr;
    logic signed [DW-1:0] r_ci;
    logic signed [DW-1:0] r_nr;
    logic signed [DW-1:0] r_ni;
    logic                 w_use_right;
    logic                 w_accept;

    logic signed [DW-1:0] w_dr;
    logic signed [DW-1:0] w_di;
    logic signed [DW-1:0] w_or;
    logic signed [DW-1:0] w_oi;

    logic                   w_mul_ready;
    logic                   w_mul_valid;
    logic signed [2*DW-1:0] w_re_prod [4];
    logic signed [2*DW-1:0] w_im_prod [4];
    logic                   w_pair_ready;
    logic                   w_pair_valid;
    logic signed [2*DW:0]   w_re_a;
    logic signed [2*DW:0]   w_re_b;
    logic signed [2*DW:0]   w_im_a;
    logic signed [2*DW:0]   w_im_b;
    logic                   w_rnd_ready;
    logic signed [DW-1:0]   w_new_re;
    logic signed [DW-1:0]   w_new_im;
    logic                   w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_DIAG_HALF_RE] <= ONE;
            r_cfg[CFG_DIAG_HALF_IM] <= '0;
            r_cfg[CFG_DIAG_FULL_RE] <= ONE;
            r_cfg[CFG_DIAG_FULL_IM] <= '0;
            r_cfg[CFG_OFF_HALF_RE]  <= '0;
            r_cfg[CFG_OFF_HALF_IM]  <= '0;
            r_cfg[CFG_OFF_FULL_RE]  <= '0;
            r_cfg[CFG_OFF_FULL_IM]  <= '0;
        end else if (i_cfg_wr_en) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_s_axis_tready = !r_in_valid || w_mul_ready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_use_right     = i_s_axis_tuser[0] ^ i_s_axis_tuser[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_mul_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_s_axis_tuser[0];
            r_cr   <= i_s_axis_tdata[3*DW-1:2*DW];
            r_ci   <= i_s_axis_tdata[4*DW-1:3*DW];
            if (w_use_right) begin
                r_nr <= i_s_axis_tdata[5*DW-1:4*DW];
                r_ni <= i_s_axis_tdata[6*DW-1:5*DW];
            end else begin
                r_nr <= i_s_axis_tdata[DW-1:0];
                r_ni <= i_s_axis_tdata[2*DW-1:DW];
            end
        end
    end

    assign w_dr = r_func ? r_cfg[CFG_DIAG_FULL_RE] : r_cfg[CFG_DIAG_HALF_RE];
    assign w_di = r_func ? r_cfg[CFG_DIAG_FULL_IM] : r_cfg[CFG_DIAG_HALF_IM];
    assign w_or = r_func ? r_cfg[CFG_OFF_FULL_RE]  : r_cfg[CFG_OFF_HALF_RE];
    assign w_oi = r_func ? r_cfg[CFG_OFF_FULL_IM]  : r_cfg[CFG_OFF_HALF_IM];

    kps_cmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .o_ready   (w_mul_ready),
        .i_dr      (w_dr),
        .i_di      (w_di),
        .i_or      (w_or),
        .i_oi      (w_oi),
        .i_cr      (r_cr),
        .i_ci      (r_ci),
        .i_nr      (r_nr),
        .i_ni      (r_ni),
        .o_valid   (w_mul_valid),
        .i_ready   (w_pair_ready),
        .o_re_prod (w_re_prod),
        .o_im_prod (w_im_prod)
    );

    kps_pair #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_mul_valid),
        .o_ready   (w_pair_ready),
        .i_re_prod (w_re_prod),
        .i_im_prod (w_im_prod),
        .o_valid   (w_pair_valid),
        .i_ready   (w_rnd_ready),
        .o_re_a    (w_re_a),
        .o_re_b    (w_re_b),
        .o_im_a    (w_im_a),
        .o_im_b    (w_im_b)
    );

    kps_round #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pair_valid),
        .o_ready  (w_rnd_ready),
        .i_re_a   (w_re_a),
        .i_re_b   (w_re_b),
        .i_im_a   (w_im_a),
        .i_im_b   (w_im_b),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_new_re (w_new_re),
        .o_new_im (w_new_im),
        .o_sat    (w_sat)
    );

    assign o_m_axis_tdata    = OUT_W'({w_new_im, w_new_re});
    assign o_m_axis_tuser[0] = w_sat;

`ifndef SYNTHESIS
    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted beat did not reach the input register");

    a_sat_means_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_sat) |->
            (w_new_re == {1'b0, {(DW-1){1'b1}}} || w_new_re == {1'b1, {(DW-1){1'b0}}} ||
             w_new_im == {1'b0, {(DW-1){1'b1}}} || w_new_im == {1'b1, {(DW-1){1'b0}}}))
        else $error("saturation flag set without a clipped part");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule : kinetic_propagator_stencil

`default_nettype wire
